### rtl/count_min_sketch_string_counter_unit_defines.svh
// Assertion macros used by the top-level RTL file.
// CMSS_ASSERT_CLK names the clock and reset, CMSS_ASSERT uses clk_i and rst_ni.
`ifndef COUNT_MIN_SKETCH_STRING_COUNTER_UNIT_DEFINES_SVH
`define COUNT_MIN_SKETCH_STRING_COUNTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CMSS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CMSS_ASSERT(lbl, prop, msg) \
  `CMSS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define CMSS_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CMSS_ASSERT(lbl, prop, msg)
`endif

`endif

### rtl/cmss_pkg.sv
package cmss_pkg;

  localparam int HASH_W      = 64;
  localparam int HASH_SHIFT  = 5;
  localparam int MOD_BITS    = 4;
  localparam int MOD_CYCLES  = HASH_W / MOD_BITS;
  localparam int MOD_CNT_W   = $clog2(MOD_CYCLES);
  localparam int CNT_W       = 31;
  localparam int BYTE_W      = 8;
  localparam int ROW_WIDTH_W = 11;
  localparam int ROW_COUNT_W = 4;
  localparam int SEED_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ROW_WIDTH_W-1:0] RST_ROW_WIDTH = 11'd1024;
  localparam logic [ROW_COUNT_W-1:0] RST_ROW_COUNT = 4'd4;
  localparam logic [SEED_W-1:0]      RST_SEED_BASE = 16'd1934;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_BASE = 2'd2;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_RMW,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              load;
    logic [BYTE_W-1:0] data;
    logic              step;
    logic              reseed;
    logic [SEED_W-1:0] seed;
  } lane_ctrl_t;

endpackage

### rtl/cmss_lane.sv
module cmss_lane #(
  parameter int MAX_WIDTH = 1024,
  parameter int ROW = 0,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmss_pkg::lane_ctrl_t ctrl_i,
  input  logic [COL_W:0]      width_i,
  output logic [COL_W-1:0]    col_o
);
  import cmss_pkg::*;

  logic [HASH_W-1:0] hash_q, hash_d;
  logic [COL_W-1:0]  rem_q, rem_d;
  logic [HASH_W-1:0] ext;
  logic [HASH_W-1:0] seed_val;
  logic [COL_W-1:0]  rem_step;

  assign ext      = {{(HASH_W - BYTE_W){ctrl_i.data[BYTE_W-1]}}, ctrl_i.data};
  assign seed_val = HASH_W'(ctrl_i.seed) + HASH_W'(ROW);

  // Restoring remainder, MOD_BITS hash bits per step, most significant first.
  always_comb begin
    logic [COL_W:0]   t;
    logic [COL_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {r, hash_q[HASH_W-1-i]};
      if (t >= width_i) begin
        t = t - width_i;
      end
      r = t[COL_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    hash_d = hash_q;
    if (ctrl_i.reseed) begin
      hash_d = seed_val;
    end else if (ctrl_i.load) begin
      hash_d = (hash_q << HASH_SHIFT) + hash_q + ext;
    end else if (ctrl_i.step) begin
      hash_d = hash_q << MOD_BITS;
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (ctrl_i.load) begin
      rem_d = '0;
    end else if (ctrl_i.step) begin
      rem_d = rem_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HASH_W'(RST_SEED_BASE) + HASH_W'(ROW);
      rem_q  <= '0;
    end else begin
      hash_q <= hash_d;
      rem_q  <= rem_d;
    end
  end

  assign col_o = rem_q;

endmodule

### rtl/count_min_sketch_string_counter_unit.sv
// Name bytes transfer one per cycle while the unit is idle; in_stall_o holds them otherwise.
// A last byte stalls the input through column reduction (4 hash bits a cycle),
// counter read-modify-write on the counter memory (one write port, one registered
// read port), and the posting of the result.
// A query estimate shows on estimate_o; an update posts no result.
// After reset a clearing pass zeroes all MAX_ROWS * MAX_WIDTH counter entries
// (8192 by default); no byte is taken then, configuration writes are.
`include "count_min_sketch_string_counter_unit_defines.svh"

module count_min_sketch_string_counter_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [cmss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [cmss_pkg::BYTE_W-1:0]     name_byte_i,
  input  logic                            last_byte_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cmss_pkg::CNT_W-1:0]      estimate_o
);
  import cmss_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = COL_W + 1;
  localparam int WEXT  = (WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int REXT  = (RCW > ROW_COUNT_W) ? RCW : ROW_COUNT_W;

  // configuration registers
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [ROW_COUNT_W-1:0] row_count_q;
  logic [SEED_W-1:0]      seed_q;
  logic                   seed_wr;

  // control
  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q;
  logic [MOD_CNT_W-1:0] mod_cnt_q;
  logic [RCW-1:0]       rcnt_q;
  logic                 req_q;
  logic [CNT_W-1:0]     min_q;
  logic                 out_valid_q;
  logic [CNT_W-1:0]     estimate_q;
  logic                 in_acc;
  logic                 out_load;
  logic                 mod_last;

  // effective width and row count
  logic [WEXT-1:0] rw_ext;
  logic [WW-1:0]   width_eff;
  logic [REXT-1:0] rc_ext;
  logic [RCW-1:0]  rows_eff;

  // lanes
  lane_ctrl_t       lane_ctrl;
  logic [COL_W-1:0] col [MAX_ROWS];
  logic [RIW-1:0]   rsel;

  // counter memory
  logic [CNT_W-1:0] cnt_mem [DEPTH];
  logic             mem_re, mem_we;
  logic [AW-1:0]    mem_raddr, mem_waddr, raddr_q;
  logic [CNT_W-1:0] mem_wdata, rd_q;

  assign seed_wr = cfg_we_i && (cfg_idx_i == REG_SEED_BASE);

  // Clamp width to 1..MAX_WIDTH and rows to 1..MAX_ROWS.
  assign rw_ext = WEXT'(row_width_q);
  assign rc_ext = REXT'(row_count_q);

  always_comb begin
    if (rw_ext == '0) begin
      width_eff = WW'(1);
    end else if (rw_ext > WEXT'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = rw_ext[WW-1:0];
    end
  end

  always_comb begin
    if (rc_ext == '0) begin
      rows_eff = RCW'(1);
    end else if (rc_ext > REXT'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = rc_ext[RCW-1:0];
    end
  end

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign mod_last = (mod_cnt_q == MOD_CNT_W'(MOD_CYCLES - 1));
  assign rsel     = rcnt_q[RIW-1:0];

  // One hash lane per row: hashes every byte, then reduces modulo the width.
  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_lane
    cmss_lane #(
      .MAX_WIDTH (MAX_WIDTH),
      .ROW       (g)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .width_i (width_eff),
      .col_o   (col[g])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && last_byte_i) state_d = S_MOD;
      end
      S_MOD: begin
        if (mod_last) state_d = S_RMW;
      end
      S_RMW: begin
        if (rcnt_q == rows_eff) state_d = S_DONE;
      end
      S_DONE: begin
        if (req_q == REQ_UPDATE || out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: lane control and memory ports.
  always_comb begin
    in_stall_o = (state_q != S_IDLE);

    lane_ctrl.load = in_acc;
    lane_ctrl.data = name_byte_i;
    lane_ctrl.step = (state_q == S_MOD);
    // Restart the hashes once the columns are taken, or on a seed write.
    lane_ctrl.reseed = seed_wr || ((state_q == S_MOD) && mod_last);
    lane_ctrl.seed   = seed_wr ? cfg_data_i[SEED_W-1:0] : seed_q;

    // Row k is read in step k and written back in step k + 1; rows are
    // distinct entries, so a write never meets the read of the same entry.
    mem_re    = (state_q == S_RMW) && (rcnt_q < rows_eff);
    mem_raddr = AW'(rsel) * AW'(MAX_WIDTH) + AW'(col[rsel]);

    mem_we    = 1'b0;
    mem_waddr = raddr_q;
    mem_wdata = (rd_q == CNT_MAX) ? rd_q : rd_q + CNT_W'(1);
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_RMW && rcnt_q != '0 && req_q == REQ_UPDATE) begin
      mem_we = 1'b1;
    end

    out_load = (state_q == S_DONE) && (req_q == REQ_QUERY)
               && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mod_cnt_q   <= '0;
      rcnt_q      <= '0;
      req_q       <= REQ_UPDATE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      mod_cnt_q <= (state_q == S_MOD) ? mod_cnt_q + MOD_CNT_W'(1) : '0;
      rcnt_q    <= (state_q == S_RMW) ? rcnt_q + RCW'(1) : '0;
      if (in_acc && last_byte_i) req_q <= req_type_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RST_ROW_WIDTH;
      row_count_q <= RST_ROW_COUNT;
      seed_q      <= RST_SEED_BASE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_WIDTH: row_width_q <= cfg_data_i[ROW_WIDTH_W-1:0];
        REG_ROW_COUNT: row_count_q <= cfg_data_i[ROW_COUNT_W-1:0];
        REG_SEED_BASE: seed_q      <= cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers: running minimum, write-back address, result.
  always_ff @(posedge clk_i) begin
    if (mem_re) raddr_q <= mem_raddr;
    if (state_q == S_RMW && rcnt_q != '0) begin
      if (rcnt_q == RCW'(1) || rd_q < min_q) min_q <= rd_q;
    end
    if (out_load) estimate_q <= min_q;
  end

  // Counter memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) cnt_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= cnt_mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = estimate_q;

  `CMSS_ASSERT(a_result_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE), "result posted outside done step")
  `CMSS_ASSERT(a_wb_addr, (state_q == S_RMW && mem_we) |-> mem_waddr == $past(mem_raddr), "write-back address differs from read")
  `CMSS_ASSERT(a_all_rows, $fell(state_q == S_RMW) |-> $past(rcnt_q == rows_eff), "not every row visited")

endmodule
